// ----- sv/apr_pkg.sv -----
// Shared types, constants and helpers for the aligned pattern replace block.
package apr_pkg;

    localparam int WORD_W                = 32;
    localparam int CFG_WORDS             = 4;
    localparam int MAX_PATTERN_WORDS_DEF = 4;
    localparam int FILL_W                = $clog2(CFG_WORDS + 1);
    localparam int LEN_W                 = 3;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LOW   = 3'd6;

    typedef struct packed {
        logic [WORD_W-1:0] in_word;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              out_last;
    } t_out_item;

    typedef struct packed {
        logic                  enable;
        logic                  first_only;
        logic [LEN_W-1:0]      pattern_words;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] replace_high;
        logic [CFG_DATA_W-1:0] replace_low;
    } t_cfg;

    // Word idx of a four-word value split over two 64-bit registers, word 0 on top.
    function automatic logic [WORD_W-1:0] pick_word(
        input logic [CFG_DATA_W-1:0] hi,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [1:0]            idx
    );
        logic [CFG_DATA_W-1:0] v;
        v = idx[1] ? lo : hi;
        return idx[0] ? v[WORD_W-1:0] : v[CFG_DATA_W-1:WORD_W];
    endfunction

endpackage

// ----- sv/apr_cfg_regs.sv -----
// Configuration register file of the aligned pattern replace block.
module apr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [apr_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0]  i_data,
    output apr_pkg::t_cfg                   o_cfg
);
    import apr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_ENABLE:        n_cfg.enable        = i_data[0];
                CFG_FIRST_ONLY:    n_cfg.first_only    = i_data[0];
                CFG_PATTERN_WORDS: n_cfg.pattern_words = i_data[LEN_W-1:0];
                CFG_PATTERN_HIGH:  n_cfg.pattern_high  = i_data;
                CFG_PATTERN_LOW:   n_cfg.pattern_low   = i_data;
                CFG_REPLACE_HIGH:  n_cfg.replace_high  = i_data;
                CFG_REPLACE_LOW:   n_cfg.replace_low   = i_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.first_only    <= 1'b0;
            r_cfg.pattern_words <= LEN_W'(CFG_WORDS);
            r_cfg.pattern_high  <= '0;
            r_cfg.pattern_low   <= '0;
            r_cfg.replace_high  <= '0;
            r_cfg.replace_low   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/apr_window.sv -----
// Word window with aligned compare, in-place replace and drain count.
module apr_window #(
    parameter int LEN_LIMIT = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_take,
    input  apr_pkg::t_in_item                           i_item,
    input  apr_pkg::t_cfg                               i_cfg,
    output logic [apr_pkg::FILL_W-1:0]                  o_emit_cnt,
    output logic [LEN_LIMIT-1:0][apr_pkg::WORD_W-1:0]   o_emit_words,
    output logic                                        o_emit_last
);
    import apr_pkg::*;

    localparam logic [FILL_W-1:0] LEN_MAX = FILL_W'(LEN_LIMIT);

    logic [WORD_W-1:0] r_win [LEN_LIMIT];
    logic [WORD_W-1:0] n_win [LEN_LIMIT];
    logic [WORD_W-1:0] ins_win [LEN_LIMIT];
    logic [WORD_W-1:0] rep_win [LEN_LIMIT];
    logic [FILL_W-1:0] rel [LEN_LIMIT];
    logic [LEN_LIMIT-1:0] in_rng;

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] fill_new;
    logic [FILL_W-1:0] len;
    logic [FILL_W-1:0] base;
    logic [FILL_W-1:0] keep;
    logic [FILL_W-1:0] cnt;
    logic              r_hit;
    logic              n_hit;
    logic              do_cmp;
    logic              same;
    logic              hit;

    always_comb begin
        // A length of zero acts as one; anything above the window acts as the window.
        if (i_cfg.pattern_words == '0) begin
            len = FILL_W'(1);
        end else if (FILL_W'(i_cfg.pattern_words) > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = FILL_W'(i_cfg.pattern_words);
        end

        fill_new = r_fill + FILL_W'(1);
        base     = fill_new - len;

        for (int i = 0; i < LEN_LIMIT; i++) begin
            rel[i]     = FILL_W'(i) - base;
            in_rng[i]  = (FILL_W'(i) >= base) && (FILL_W'(i) < fill_new);
            ins_win[i] = (FILL_W'(i) == r_fill) ? i_item.in_word : r_win[i];
        end

        do_cmp = i_cfg.enable && (fill_new >= len) && !(i_cfg.first_only && r_hit);

        same = 1'b1;
        for (int i = 0; i < LEN_LIMIT; i++) begin
            if (in_rng[i] &&
                ins_win[i] != pick_word(i_cfg.pattern_high, i_cfg.pattern_low, rel[i][1:0])) begin
                same = 1'b0;
            end
        end
        hit = do_cmp && same;

        for (int i = 0; i < LEN_LIMIT; i++) begin
            rep_win[i] = (hit && in_rng[i])
                       ? pick_word(i_cfg.replace_high, i_cfg.replace_low, rel[i][1:0])
                       : ins_win[i];
        end

        // The last word drains the whole window; otherwise len-1 words stay behind.
        keep = i_item.in_last ? '0 : len - FILL_W'(1);
        cnt  = (fill_new > keep) ? fill_new - keep : '0;

        for (int i = 0; i < LEN_LIMIT; i++) begin
            n_win[i] = '0;
            for (int k = 0; k < LEN_LIMIT; k++) begin
                if (FILL_W'(k) == FILL_W'(i) + cnt) begin
                    n_win[i] = rep_win[k];
                end
            end
        end

        n_fill = i_item.in_last ? '0 : fill_new - cnt;
        n_hit  = i_item.in_last ? 1'b0 : (r_hit | hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_hit  <= 1'b0;
        end else if (i_take) begin
            r_fill <= n_fill;
            r_hit  <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        for (int i = 0; i < LEN_LIMIT; i++) begin
            o_emit_words[i] = rep_win[i];
        end
    end

    assign o_emit_cnt  = i_take ? cnt : '0;
    assign o_emit_last = i_item.in_last;

endmodule

// ----- sv/apr_out_queue.sv -----
// Shifting result queue: takes up to one window of words per cycle, hands out one per pop.
module apr_out_queue #(
    parameter int LANES = 4,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [apr_pkg::FILL_W-1:0]              i_push_cnt,
    input  logic [LANES-1:0][apr_pkg::WORD_W-1:0]   i_push_words,
    input  logic                                    i_push_last,
    input  logic                                    i_pop,
    output apr_pkg::t_out_item                      o_item,
    output logic                                    o_valid,
    output logic                                    o_room
);
    import apr_pkg::*;

    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] r_word [DEPTH];
    logic [WORD_W-1:0] n_word [DEPTH];
    logic [DEPTH-1:0]  r_last;
    logic [DEPTH-1:0]  n_last;
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;
    logic [LVL_W-1:0]  occ;

    always_comb begin
        occ = r_level - LVL_W'(i_pop);
        for (int s = 0; s < DEPTH; s++) begin
            if (i_pop && (s + 1 < DEPTH)) begin
                n_word[s] = r_word[(s + 1) % DEPTH];
                n_last[s] = r_last[(s + 1) % DEPTH];
            end else begin
                n_word[s] = r_word[s];
                n_last[s] = r_last[s];
            end
            // New words land right behind what remains after the pop.
            for (int l = 0; l < LANES; l++) begin
                if ((s == int'(occ) + l) && (FILL_W'(l) < i_push_cnt)) begin
                    n_word[s] = i_push_words[l];
                    n_last[s] = i_push_last && (FILL_W'(l + 1) == i_push_cnt);
                end
            end
        end
        n_level = occ + LVL_W'(i_push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_last <= n_last;
    end

    assign o_valid         = (r_level != '0);
    assign o_room          = (r_level <= LVL_W'(DEPTH - LANES));
    assign o_item.out_word = r_word[0];
    assign o_item.out_last = r_last[0];

endmodule

// ----- sv/aligned_pattern_replace.sv -----
// Aligned pattern replace top level: window compare/replace in front of a result queue.
// Throughput: one word per cycle in and out when not stalled; each accepted word is compared
// and replaced in the cycle it is taken. A word is released once pattern_words-1 later words
// have arrived (or at the buffer's last word) and is registered into the result queue.
// The input stalls only while the result queue lacks room for a full window drain.
// Synchronous active-low reset clears the window fill, hit flag, queue and registers.
module aligned_pattern_replace #(
    parameter int MAX_PATTERN_WORDS = apr_pkg::MAX_PATTERN_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  apr_pkg::t_in_item               i_in,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output apr_pkg::t_out_item              o_out,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [apr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import apr_pkg::*;

    localparam int LEN_LIMIT   = (MAX_PATTERN_WORDS < CFG_WORDS) ? MAX_PATTERN_WORDS
                                                                 : CFG_WORDS;
    localparam int QUEUE_DEPTH = 2 * LEN_LIMIT;

    t_cfg                             cfg;
    logic                             take;
    logic                             pop;
    logic                             room;
    logic [FILL_W-1:0]                emit_cnt;
    logic [LEN_LIMIT-1:0][WORD_W-1:0] emit_words;
    logic                             emit_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !room;
    assign take        = i_in_valid && room;
    assign pop         = o_out_valid && !i_out_stall;

    apr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    apr_window #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_item       (i_in),
        .i_cfg        (cfg),
        .o_emit_cnt   (emit_cnt),
        .o_emit_words (emit_words),
        .o_emit_last  (emit_last)
    );

    apr_out_queue #(
        .LANES (LEN_LIMIT),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (emit_cnt),
        .i_push_words (emit_words),
        .i_push_last  (emit_last),
        .i_pop        (pop),
        .o_item       (o_out),
        .o_valid      (o_out_valid),
        .o_room       (room)
    );

`ifndef SYNTHESIS
    // The last beat of a buffer always flushes at least itself.
    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in.in_last) |-> (emit_cnt != '0))
        else $error("last beat produced no output words");

    // A single beat never drains more words than the window holds.
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (emit_cnt <= FILL_W'(LEN_LIMIT)))
        else $error("drain count exceeds window depth");

    // Right after reset the queue is empty and the input is open.
    a_reset_state: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_in_stall && !o_out_valid))
        else $error("block not empty and open after reset");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the aligned pattern replace block.
module testbench;
    import apr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int WIN_MAX      = CFG_WORDS;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic [WORD_W-1:0] WORD_A = 32'hDEAD_BEEF;
    localparam logic [WORD_W-1:0] WORD_B = 32'h0BAD_F00D;
    localparam logic [WORD_W-1:0] WORD_C = 32'hCAFE_0001;
    localparam logic [WORD_W-1:0] WORD_D = 32'h7654_3210;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in        = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predictor state: register copy, word window and the expected output beats.
    t_cfg                  regs;
    logic [WORD_W-1:0]     win [WIN_MAX];
    int                    win_fill;
    logic                  hit_done;
    t_out_item             pending_words[$];

    int errors        = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    aligned_pattern_replace uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int active_len();
        int n;
        n = int'(regs.pattern_words);
        if (n < 1) n = 1;
        if (n > WIN_MAX) n = WIN_MAX;
        return n;
    endfunction

    // Word i of the four words held in a high/low register pair, word 0 on top.
    function automatic logic [WORD_W-1:0] reg_word(input logic [CFG_DATA_W-1:0] hi,
                                                   input logic [CFG_DATA_W-1:0] lo,
                                                   input int i);
        logic [2*CFG_DATA_W-1:0] both;
        both = {hi, lo};
        return both[2*CFG_DATA_W-1-WORD_W*i -: WORD_W];
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE:        regs.enable        = data[0];
            CFG_FIRST_ONLY:    regs.first_only    = data[0];
            CFG_PATTERN_WORDS: regs.pattern_words = data[LEN_W-1:0];
            CFG_PATTERN_HIGH:  regs.pattern_high  = data;
            CFG_PATTERN_LOW:   regs.pattern_low   = data;
            CFG_REPLACE_HIGH:  regs.replace_high  = data;
            CFG_REPLACE_LOW:   regs.replace_low   = data;
            default: ;
        endcase
    endfunction

    // Pushes the word into the window, replaces on a match and queues released words.
    function automatic void scan_word(input logic [WORD_W-1:0] word, input logic last);
        int        n;
        int        keep;
        int        base;
        logic      same;
        t_out_item item;
        n = active_len();
        if (win_fill < WIN_MAX) begin
            win[win_fill] = word;
            win_fill++;
        end
        if (regs.enable && win_fill >= n && !(regs.first_only && hit_done)) begin
            base = win_fill - n;
            same = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (win[base+i] !== reg_word(regs.pattern_high, regs.pattern_low, i)) same = 1'b0;
            end
            if (same) begin
                for (int i = 0; i < n; i++) begin
                    win[base+i] = reg_word(regs.replace_high, regs.replace_low, i);
                end
                hit_done = 1'b1;
            end
        end
        keep = last ? 0 : n - 1;
        while (win_fill > keep) begin
            item.out_word = win[0];
            item.out_last = last && (win_fill == 1);
            pending_words.push_back(item);
            for (int i = 1; i < win_fill; i++) win[i-1] = win[i];
            win_fill--;
            win[win_fill] = '0;
        end
        if (last) begin
            win_fill = 0;
            hit_done = 1'b0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in.in_word   <= word;
        i_in.in_last   <= last;
        do @(posedge i_clk); while (o_in_stall);
        scan_word(word, last);
        @(negedge i_clk);
    endtask

    // Lets every expected beat arrive, then gives the block time to settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes all registers; unused upper bits of the narrow ones carry random junk.
    task automatic set_regs(input logic en, input logic fo, input logic [LEN_W-1:0] pw,
                            input logic [CFG_DATA_W-1:0] ph, input logic [CFG_DATA_W-1:0] pl,
                            input logic [CFG_DATA_W-1:0] rh, input logic [CFG_DATA_W-1:0] rl);
        logic [CFG_DATA_W-1:0] d;
        d = {$urandom, $urandom};
        d[0] = en;
        write_reg(CFG_ENABLE, d);
        d = {$urandom, $urandom};
        d[0] = fo;
        write_reg(CFG_FIRST_ONLY, d);
        d = {$urandom, $urandom};
        d[LEN_W-1:0] = pw;
        write_reg(CFG_PATTERN_WORDS, d);
        write_reg(CFG_PATTERN_HIGH, ph);
        write_reg(CFG_PATTERN_LOW, pl);
        write_reg(CFG_REPLACE_HIGH, rh);
        write_reg(CFG_REPLACE_LOW, rl);
    endtask

    task automatic random_regs();
        logic [CFG_DATA_W-1:0] ph, pl, rh, rl;
        logic [LEN_W-1:0]      pw;
        pw = ($urandom_range(99) < 80) ? LEN_W'($urandom_range(4, 1))
                                       : LEN_W'($urandom_range(7, 0));
        ph = {$urandom, $urandom};
        pl = {$urandom, $urandom};
        rh = {$urandom, $urandom};
        rl = {$urandom, $urandom};
        // A pattern of one repeated word makes overlapping matches likely.
        if ($urandom_range(99) < 15) begin
            ph = {2{ph[WORD_W-1:0]}};
            pl = ph;
        end
        // A rotated pattern as replacement lets the rewritten data match again.
        if ($urandom_range(99) < 25) begin
            rh = {ph[WORD_W-1:0], pl[CFG_DATA_W-1:WORD_W]};
            rl = {pl[WORD_W-1:0], ph[CFG_DATA_W-1:WORD_W]};
        end
        set_regs($urandom_range(99) < 85, 1'($urandom_range(1)), pw, ph, pl, rh, rl);
    endtask

    task automatic test_passthrough();
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'hA5A5_A5A5, 1'b1);
        wait_idle();
    endtask

    task automatic test_replace_chain();
        set_regs(1'b1, 1'b0, 3'd2, {WORD_A, WORD_B}, {WORD_D, WORD_D},
                 {WORD_C, WORD_A}, {WORD_D, WORD_D});
        send_word(WORD_A, 1'b0);
        send_word(WORD_B, 1'b0);
        send_word(WORD_B, 1'b0);
        send_word(WORD_B, 1'b1);
        wait_idle();
    endtask

    task automatic test_first_only();
        write_reg(CFG_FIRST_ONLY, 64'd1);
        send_word(WORD_A, 1'b0);
        send_word(WORD_B, 1'b0);
        send_word(WORD_B, 1'b0);
        send_word(WORD_B, 1'b1);
        // The hit flag clears at the end of a buffer.
        send_word(WORD_A, 1'b0);
        send_word(WORD_B, 1'b1);
        wait_idle();
    endtask

    task automatic test_length_range();
        set_regs(1'b1, 1'b0, 3'd0, {WORD_A, WORD_B}, {WORD_C, WORD_D},
                 {WORD_C, WORD_D}, {WORD_A, WORD_B});
        send_word(WORD_B, 1'b0);
        send_word(WORD_A, 1'b0);
        send_word(WORD_A, 1'b1);
        wait_idle();
        write_reg(CFG_PATTERN_WORDS, 64'd7);
        send_word(WORD_A, 1'b0);
        send_word(WORD_B, 1'b0);
        send_word(WORD_C, 1'b0);
        send_word(WORD_D, 1'b1);
        wait_idle();
        // A tail shorter than the pattern passes unchanged.
        write_reg(CFG_PATTERN_WORDS, 64'd5);
        send_word(WORD_A, 1'b0);
        send_word(WORD_B, 1'b1);
        wait_idle();
    endtask

    task automatic test_unused_register();
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        send_word(WORD_A, 1'b1);
        wait_idle();
    endtask

    task automatic test_shrink_mid_buffer();
        set_regs(1'b1, 1'b0, 3'd4, {WORD_A, WORD_B}, {WORD_C, WORD_D},
                 {WORD_C, WORD_D}, {WORD_B, WORD_A});
        send_word(WORD_D, 1'b0);
        send_word(WORD_B, 1'b0);
        send_word(WORD_A, 1'b0);
        wait_idle();
        write_reg(CFG_PATTERN_WORDS, 64'd2);
        send_word(WORD_B, 1'b0);
        send_word(WORD_A, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_buffers(input int s_idle, input int r_idle, input int n_items);
        logic [WORD_W-1:0] words[$];
        int                sent;
        int                len;
        int                n;
        int                m;
        int                r;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_items) begin
            if (sent == 0 || $urandom_range(99) < 30) begin
                wait_idle();
                random_regs();
            end
            n = active_len();
            len = $urandom_range(10, 1);
            words.delete();
            while (words.size() < len) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    for (int k = 0; k < n; k++) begin
                        words.push_back(reg_word(regs.pattern_high, regs.pattern_low, k));
                    end
                end else if (r < 55) begin
                    m = $urandom_range(n, 1);
                    for (int k = 0; k < m; k++) begin
                        words.push_back(reg_word(regs.pattern_high, regs.pattern_low, k));
                    end
                    words.push_back($urandom);
                end else if (r < 62) begin
                    words.push_back(reg_word(regs.replace_high, regs.replace_low,
                                             $urandom_range(3, 0)));
                end else if (r < 70) begin
                    words.push_back($urandom_range(1) ? '0 : '1);
                end else begin
                    words.push_back($urandom);
                end
            end
            foreach (words[k]) send_word(words[k], k == words.size() - 1);
            sent += words.size();
        end
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compares every accepted output beat with the oldest expected one.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: beat with nothing expected, actual word %h last %b",
                         $time, o_out.out_word, o_out.out_last);
            end else begin
                want = pending_words.pop_front();
                if (o_out.out_word !== want.out_word) begin
                    errors++;
                    $display("%0t: out_word expected %h actual %h",
                             $time, want.out_word, o_out.out_word);
                end
                if (o_out.out_last !== want.out_last) begin
                    errors++;
                    $display("%0t: out_last expected %b actual %b",
                             $time, want.out_last, o_out.out_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        regs = '0;
        regs.pattern_words = 3'd4;
        foreach (win[i]) win[i] = '0;
        win_fill = 0;
        hit_done = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 52;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_passthrough();
        test_replace_chain();
        test_first_only();
        test_length_range();
        test_unused_register();
        test_shrink_mid_buffer();
        test_random_buffers(37, 52, 90);
        test_random_buffers(52, 37, 90);
        test_random_buffers(0, 0, 90);

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
